[sv/bfha_pkg.sv]
// Shared types and constants for the best-fit heap allocator.
// Segment table entry layout, status codes and controller states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bfha_pkg;

  localparam int ADDR_W = 21;
  localparam int SPLIT_SLACK = 4;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] size;
    logic              free;
  } seg_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NOFIT   = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_UNKNOWN = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_DECIDE,
    S_SH_RD,
    S_SH_WR,
    S_WR_NEW,
    S_WR_BEST,
    S_CO_RD,
    S_CO_EV,
    S_CO_LAST,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

[sv/best_fit_heap_allocator_unit.sv]
// Best-fit heap allocator top level: segment table memory and its sequencer.
// Depends on bfha_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Keeps an address-ordered table of heap segments in one synchronous RAM of
// MAX_BLOCKS entries. One request is handled at a time; s_tready is high only
// while the sequencer is idle and out of reset. Every entry step is a RAM
// read, then an evaluate. An allocate runs the best-fit scan over the N live
// segments, the decision, the write-back and the output load. A split adds
// a write of the new entry and moves each entry above it up to open its slot.
// A free runs an address lookup over the table, then a merge pass that
// compacts it. A failed allocate or an unknown free address goes from the
// decision straight to the output load, and a null free skips the table.
// The result sits in an output register and is held until taken.
module best_fit_heap_allocator_unit
  import bfha_pkg::*;
#(
  parameter int HEAP_BYTES   = 1048576,
  parameter int HEADER_BYTES = 12,
  parameter int MAX_BLOCKS   = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // req_size[20:0], block_addr[41:21], zero pad
  input  wire logic [0:0]  s_tuser,   // func
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata    // result_addr[20:0], status[22:21], zero pad
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [ADDR_W-1:0] HDR = ADDR_W'(HEADER_BYTES);
  localparam logic [ADDR_W-1:0] INIT_SIZE = ADDR_W'(HEAP_BYTES - HEADER_BYTES);

  seg_t mem [MAX_BLOCKS];
  seg_t rdata;
  seg_t wdata;
  logic we;
  logic [IW-1:0] waddr;
  logic [IW-1:0] rd_addr;

  state_t state, state_next;

  func_t             func;
  logic [ADDR_W-1:0] req;
  logic [ADDR_W-1:0] addr;
  logic [CW-1:0]     seg_count;
  logic [CW-1:0]     idx;
  logic              found;
  logic [IW-1:0]     best;
  logic [ADDR_W-1:0] best_start;
  logic [ADDR_W-1:0] best_size;
  logic [IW-1:0]     k;
  logic [IW-1:0]     w;
  logic              have_acc;
  seg_t              acc;
  logic [ADDR_W-1:0] res_addr;
  status_t           res_status;

  logic  accept;
  logic  split;
  logic  fits;
  logic  hit;
  logic  merge;
  seg_t  co_ent;
  seg_t  new_ent;
  logic  out_load;

  assign accept   = s_tvalid && s_tready;
  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  assign split = {2'b00, best_size} >
                 ({2'b00, req} + (ADDR_W+2)'(HEADER_BYTES) + (ADDR_W+2)'(SPLIT_SLACK));
  assign fits  = rdata.free && (rdata.size >= req) && (!found || rdata.size < best_size);
  assign hit   = !found && ((rdata.start + HDR) == addr);

  always_comb begin
    co_ent = rdata;
    if (idx[IW-1:0] == best) begin
      co_ent.free = 1'b1;
    end
  end
  assign merge = have_acc && acc.free && co_ent.free;

  assign new_ent.start = best_start + HDR + req;
  assign new_ent.size  = best_size - req - HDR;
  assign new_ent.free  = 1'b1;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser[0] == FUNC_FREE && s_tdata[41:21] == '0) begin
            state_next = S_DONE;
          end else begin
            state_next = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: state_next = S_SCAN_EV;
      S_SCAN_EV: begin
        if (idx + CW'(1) == seg_count) begin
          state_next = S_DECIDE;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_DECIDE: begin
        if (!found) begin
          state_next = S_DONE;
        end else if (func == FUNC_FREE) begin
          state_next = S_CO_RD;
        end else if (split && seg_count == CW'(MAX_BLOCKS)) begin
          state_next = S_DONE;
        end else if (split) begin
          if (seg_count[IW-1:0] > best + IW'(1)) begin
            state_next = S_SH_RD;
          end else begin
            state_next = S_WR_NEW;
          end
        end else begin
          state_next = S_WR_BEST;
        end
      end
      S_SH_RD: state_next = S_SH_WR;
      S_SH_WR: begin
        if (k - IW'(1) > best + IW'(1)) begin
          state_next = S_SH_RD;
        end else begin
          state_next = S_WR_NEW;
        end
      end
      S_WR_NEW:  state_next = S_WR_BEST;
      S_WR_BEST: state_next = S_DONE;
      S_CO_RD:   state_next = S_CO_EV;
      S_CO_EV: begin
        if (idx + CW'(1) == seg_count) begin
          state_next = S_CO_LAST;
        end else begin
          state_next = S_CO_RD;
        end
      end
      S_CO_LAST: state_next = S_DONE;
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memory control outputs
  always_comb begin
    s_tready = (state == S_IDLE) && !rst;
    we       = 1'b0;
    waddr    = '0;
    wdata    = acc;
    rd_addr  = '0;
    unique case (state)
      S_SCAN_RD: rd_addr = idx[IW-1:0];
      S_SH_RD:   rd_addr = k - IW'(1);
      S_CO_RD:   rd_addr = idx[IW-1:0];
      S_SH_WR: begin
        we    = 1'b1;
        waddr = k;
        wdata = rdata;
      end
      S_WR_NEW: begin
        we    = 1'b1;
        waddr = best + IW'(1);
        wdata = new_ent;
      end
      S_WR_BEST: begin
        we          = 1'b1;
        waddr       = best;
        wdata.start = best_start;
        wdata.size  = split ? req : best_size;
        wdata.free  = 1'b0;
      end
      S_CO_EV: begin
        we    = have_acc && !merge;
        waddr = w;
        wdata = acc;
      end
      S_CO_LAST: begin
        we    = 1'b1;
        waddr = w;
        wdata = acc;
      end
      default: ;
    endcase
    if (rst) begin
      we          = 1'b1;
      waddr       = '0;
      wdata.start = '0;
      wdata.size  = INIT_SIZE;
      wdata.free  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      seg_count <= CW'(1);
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == S_WR_NEW) begin
        seg_count <= seg_count + CW'(1);
      end
      if (state == S_CO_LAST) begin
        seg_count <= CW'(w) + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {1'b0, res_status, res_addr};
    end
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          func       <= func_t'(s_tuser[0]);
          req        <= s_tdata[20:0];
          addr       <= s_tdata[41:21];
          idx        <= '0;
          found      <= 1'b0;
          res_addr   <= '0;
          res_status <= STAT_OK;
        end
      end
      S_SCAN_EV: begin
        if (func == FUNC_ALLOC ? fits : hit) begin
          found      <= 1'b1;
          best       <= idx[IW-1:0];
          best_start <= rdata.start;
          best_size  <= rdata.size;
        end
        idx <= idx + CW'(1);
      end
      S_DECIDE: begin
        k        <= seg_count[IW-1:0];
        idx      <= '0;
        w        <= '0;
        have_acc <= 1'b0;
        if (!found) begin
          res_status <= (func == FUNC_FREE) ? STAT_UNKNOWN : STAT_NOFIT;
        end else if (func == FUNC_ALLOC) begin
          if (split && seg_count == CW'(MAX_BLOCKS)) begin
            res_status <= STAT_FULL;
          end else begin
            res_addr <= best_start + HDR;
          end
        end
      end
      S_SH_WR: k <= k - IW'(1);
      S_CO_EV: begin
        have_acc <= 1'b1;
        if (merge) begin
          acc.size <= acc.size + co_ent.size + HDR;
        end else begin
          acc <= co_ent;
          if (have_acc) begin
            w <= w + IW'(1);
          end
        end
        idx <= idx + CW'(1);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[sv/bfha_checker.sv]
// Port-level checks for best_fit_heap_allocator_unit, bound to the top level.
// Depends on bfha_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bfha_checker
  import bfha_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata
);

  // failed request reports a null address
  a_fail_addr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[22:21] != STAT_OK |-> m_tdata[20:0] == '0)
    else $error("failed request with nonzero address");

  // one request in flight
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // output idle right after reset
  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind best_fit_heap_allocator_unit bfha_checker u_bfha_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

[bench/best_fit_heap_allocator_unit_tb.sv]
// Testbench for best_fit_heap_allocator_unit: directed table, then random
// allocate/free traffic checked against a local segment-table predictor.
// Depends on bfha_pkg and the allocator RTL.
`timescale 1ns / 1ps
module best_fit_heap_allocator_unit_tb
  import bfha_pkg::*;
;

  localparam int HEAP = 1048576;
  localparam int HDR = 12;
  localparam int NBLK = 64;
  localparam int MASK = 21'h1FFFFF;
  localparam int LIMIT = 4000000;

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [47:0] s_tdata;
  logic [0:0] s_tuser;
  logic [23:0] m_tdata;

  best_fit_heap_allocator_unit uut (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata)
  );

  typedef struct packed {
    logic [20:0] addr;
    status_t     status;
  } reply_t;

  typedef struct {
    func_t       op;
    logic [20:0] size;
    logic [20:0] baddr;
    bit          typed;
    reply_t      want;
  } row_t;

  int unsigned tbl_start[NBLK];
  int unsigned tbl_size[NBLK];
  bit          tbl_free[NBLK];
  int unsigned tbl_count;
  reply_t      pending_replies[$];
  int unsigned live_addrs[$];
  int          errors = 0;
  int          cycles = 0;
  int          n_alloc = 0, n_free = 0, n_done = 0;
  row_t        rows[$];

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  function automatic void table_reset();
    tbl_start[0] = 0;
    tbl_size[0] = HEAP - HDR;
    tbl_free[0] = 1;
    tbl_count = 1;
  endfunction

  function automatic void drop_entry(int unsigned idx);
    for (int unsigned k = idx; k + 1 < tbl_count; k++) begin
      tbl_start[k] = tbl_start[k+1];
      tbl_size[k] = tbl_size[k+1];
      tbl_free[k] = tbl_free[k+1];
    end
    tbl_count--;
  endfunction

  function automatic reply_t heap_predict(func_t op, int unsigned req, int unsigned addr);
    reply_t r;
    bit found, hit;
    int unsigned best, i;
    r.addr = '0;
    r.status = STAT_OK;
    found = 0;
    best = 0;
    hit = 0;
    if (op == FUNC_ALLOC) begin
      for (i = 0; i < tbl_count; i++)
        if (tbl_free[i] && tbl_size[i] >= req && (!found || tbl_size[i] < tbl_size[best])) begin
          best = i;
          found = 1;
        end
      if (!found) r.status = STAT_NOFIT;
      else if (tbl_size[best] > req + HDR + SPLIT_SLACK && tbl_count >= NBLK)
        r.status = STAT_FULL;
      else begin
        if (tbl_size[best] > req + HDR + SPLIT_SLACK) begin
          for (i = tbl_count; i > best + 1; i--) begin
            tbl_start[i] = tbl_start[i-1];
            tbl_size[i] = tbl_size[i-1];
            tbl_free[i] = tbl_free[i-1];
          end
          tbl_start[best+1] = (tbl_start[best] + HDR + req) & MASK;
          tbl_size[best+1] = tbl_size[best] - req - HDR;
          tbl_free[best+1] = 1;
          tbl_count++;
          tbl_size[best] = req;
        end
        tbl_free[best] = 0;
        r.addr = 21'((tbl_start[best] + HDR) & MASK);
      end
    end else if (addr != 0) begin
      for (i = 0; i < tbl_count && !hit; i++)
        if (((tbl_start[i] + HDR) & MASK) == addr) begin
          tbl_free[i] = 1;
          hit = 1;
        end
      if (hit) begin
        i = 0;
        while (i + 1 < tbl_count) begin
          if (tbl_free[i] && tbl_free[i+1]) begin
            tbl_size[i] = (tbl_size[i] + tbl_size[i+1] + HDR) & MASK;
            drop_entry(i + 1);
          end else i++;
        end
      end else r.status = STAT_UNKNOWN;
    end
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 150);
    return $urandom_range(0, 3);
  endfunction

  // result side: random stalls, compare against oldest expectation
  initial begin
    int g;
    m_tready = 0;
    forever begin
      @(negedge clk);
      g = gap_len();
      if ((cycles / 3000) % 4 == 1) g = 0;
      if (g > 0) begin
        m_tready <= 0;
        repeat (g) @(negedge clk);
      end
      m_tready <= 1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      if (pending_replies.size() == 0) begin
        $error("unexpected result %h", m_tdata);
        errors++;
      end else begin
        reply_t w;
        w = pending_replies.pop_front();
        if (m_tdata[20:0] !== w.addr) begin
          $error("result_addr expected %0d actual %0d", w.addr, m_tdata[20:0]);
          errors++;
        end
        if (m_tdata[22:21] !== w.status) begin
          $error("status expected %0d actual %0d", w.status, m_tdata[22:21]);
          errors++;
        end
        if (m_tdata[23] !== 1'b0) begin
          $error("pad expected 0 actual %b", m_tdata[23]);
          errors++;
        end
      end
      n_done++;
    end
  end

  task automatic send_request(func_t op, logic [20:0] size, logic [20:0] baddr,
                              bit typed, reply_t want);
    reply_t p;
    int g;
    g = gap_len();
    @(negedge clk);
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= op;
    s_tdata <= {6'd0, baddr, size};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    p = heap_predict(op, 32'(size), 32'(baddr));
    if (typed && p !== want) begin
      $error("table row: expected %h predicted %h", want, p);
      errors++;
    end
    pending_replies.push_back(p);
    if (op == FUNC_ALLOC) begin
      n_alloc++;
      if (p.status == STAT_OK) live_addrs.push_back(32'(p.addr));
    end else n_free++;
  endtask

  function automatic void add_row(func_t op, int unsigned size, int unsigned baddr,
                                  bit typed, int unsigned waddr, status_t wst);
    row_t r;
    r.op = op;
    r.size = 21'(size);
    r.baddr = 21'(baddr);
    r.typed = typed;
    r.want.addr = 21'(waddr);
    r.want.status = wst;
    rows.push_back(r);
  endfunction

  initial begin
    int idx;
    logic [20:0] a;
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    s_tuser = FUNC_ALLOC;
    table_reset();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    add_row(FUNC_FREE, 0, 0, 1, 0, STAT_OK);
    add_row(FUNC_FREE, 0, 21'h1FFFFF, 1, 0, STAT_UNKNOWN);
    add_row(FUNC_ALLOC, 21'h1FFFFF, 0, 1, 0, STAT_NOFIT);
    add_row(FUNC_ALLOC, HEAP - HDR + 1, 0, 1, 0, STAT_NOFIT);
    add_row(FUNC_ALLOC, 0, 21'h1FFFFF, 1, HDR, STAT_OK);
    add_row(FUNC_ALLOC, 100, 0, 1, 2 * HDR, STAT_OK);
    add_row(FUNC_FREE, 21'h1FFFFF, HDR, 1, 0, STAT_OK);
    add_row(FUNC_FREE, 0, HDR, 1, 0, STAT_OK);
    add_row(FUNC_FREE, 0, 2 * HDR, 0, 0, STAT_OK);
    add_row(FUNC_ALLOC, HEAP - HDR, 0, 1, HDR, STAT_OK);
    add_row(FUNC_ALLOC, 0, 0, 1, 0, STAT_NOFIT);
    add_row(FUNC_FREE, 0, HDR, 1, 0, STAT_OK);
    add_row(FUNC_ALLOC, HEAP - 2 * HDR - 4, 0, 0, 0, STAT_OK);
    add_row(FUNC_ALLOC, 0, 0, 0, 0, STAT_OK);
    add_row(FUNC_FREE, 0, HDR, 0, 0, STAT_OK);
    add_row(FUNC_ALLOC, 5, 0, 0, 0, STAT_OK);
    add_row(FUNC_FREE, 0, 13, 1, 0, STAT_UNKNOWN);
    add_row(FUNC_FREE, 0, HDR, 0, 0, STAT_OK);
    foreach (rows[i]) send_request(rows[i].op, rows[i].size, rows[i].baddr,
                                   rows[i].typed, rows[i].want);
    live_addrs.delete();

    // random allocate/free churn; frees are mostly valid frees of live blocks
    for (int n = 0; n < 1900; n++) begin
      int k;
      int unsigned sz;
      k = $urandom_range(0, 99);
      if (k < 50) begin
        case ($urandom_range(0, 9))
          0: sz = $urandom_range(0, 21'h1FFFFF);
          1: sz = $urandom_range(0, 20);
          2: sz = $urandom_range(HEAP / 4, HEAP);
          default: sz = $urandom_range(0, 4096);
        endcase
        send_request(FUNC_ALLOC, 21'(sz), 21'($urandom), 0, '0);
      end else if (k < 92 && live_addrs.size() > 0) begin
        idx = $urandom_range(0, live_addrs.size() - 1);
        a = 21'(live_addrs[idx]);
        live_addrs.delete(idx);
        send_request(FUNC_FREE, 21'($urandom), a, 0, '0);
      end else if (k < 96) begin
        send_request(FUNC_FREE, 21'($urandom), 21'($urandom), 0, '0);
      end else begin
        send_request(FUNC_FREE, 21'($urandom), '0, 0, '0);
      end
    end
    @(negedge clk);
    s_tvalid <= 0;

    while (pending_replies.size() > 0) @(posedge clk);
    repeat (600) @(posedge clk);
    $display("ran %0d allocates and %0d frees, %0d results checked",
             n_alloc, n_free, n_done);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

[sim.f]
sv/bfha_pkg.sv
sv/best_fit_heap_allocator_unit.sv
sv/bfha_checker.sv
bench/best_fit_heap_allocator_unit_tb.sv
